>>> hw/rtl/sfsa_pkg.sv
package sfsa_pkg;

   localparam logic [1:0] OP_HEADER = 2'd0;
   localparam logic [1:0] OP_DATA   = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   localparam logic [1:0] CLASS_CURRENT = 2'd0;
   localparam logic [1:0] CLASS_NEXT    = 2'd1;
   localparam logic [1:0] CLASS_IGNORED = 2'd2;
   localparam logic [1:0] CLASS_RESYNC  = 2'd3;

   localparam logic CSR_NEXT_LIMIT   = 1'b0;
   localparam logic CSR_IGNORE_LIMIT = 1'b1;

   localparam logic [7:0] LIMIT_RESET = 8'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] message_sequence;
      logic        end_of_frame;
      logic [12:0] range_start;
      logic [12:0] range_end;
      logic [7:0]  data_byte;
      logic        last_of_message;
      logic [11:0] read_address;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [31:0] frame_sequence;
      logic        output_updated;
      logic [1:0]  message_class;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic clear;
      logic copy_read;
   } cmd_type;

   typedef struct packed {
      logic need_copy;
      logic sweep_last;
   } status_type;

endpackage

>>> hw/rtl/sfsa_datapath.sv
module sfsa_datapath
   import sfsa_pkg::*;
#(
   parameter int FRAME_BYTES = 4096
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_payload,
   input  cmd_type    cmd,
   output status_type status,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [7:0] csr_write_data,
   output rsp_type    rsp_payload
);

   localparam int AW = $clog2(FRAME_BYTES);
   localparam logic [16:0] FRAME_LIMIT = 17'(FRAME_BYTES);
   localparam logic [AW-1:0] LAST_ADDR = AW'(FRAME_BYTES - 1);

   function automatic logic [7:0] saturate(input logic [8:0] value);
      return value[8] ? 8'hFF : value[7:0];
   endfunction

   logic [7:0] frame0_mem [0:FRAME_BYTES-1];
   logic [7:0] frame1_mem [0:FRAME_BYTES-1];
   logic [7:0] output_mem [0:FRAME_BYTES-1];
   logic [7:0] frame0_rd_ff, frame1_rd_ff, output_rd_ff;

   logic [31:0]   seq_ff, seq_in;
   logic [7:0]    next_cnt_ff, next_cnt_in;
   logic [7:0]    ign_cnt_ff, ign_cnt_in;
   logic [1:0]    class_ff, class_in;
   logic [12:0]   offset_ff, offset_in;
   logic [12:0]   seg_end_ff, seg_end_in;
   logic          write_on_ff, write_on_in;
   logic          write_next_ff, write_next_in;
   logic          pending_ff, pending_in;
   logic          sel_ff, sel_in;
   logic [7:0]    next_limit_ff, next_limit_in;
   logic [7:0]    ign_limit_ff, ign_limit_in;
   logic          updated_ff, updated_in;
   logic          rd_hit_ff, rd_hit_in;
   logic          copy_bank_ff, copy_bank_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic          copy_wr_ff, copy_wr_in;
   logic [AW-1:0] copy_addr_ff, copy_addr_in;

   logic [31:0] seq_plus;
   logic        is_cur, is_next, next_over, ign_over, advance;
   logic [8:0]  next_raised, ign_raised;
   logic        hdr_copy, data_copy, in_range, data_wr, bank, addr_hit;
   logic [AW-1:0] data_addr;
   logic        f0_we, f1_we, out_we;
   logic [AW-1:0] frame_wa, out_wa;
   logic [7:0]  frame_wd, out_wd;

   // header, data and read decode
   always_comb begin
      seq_plus    = seq_ff + 32'd1;
      is_cur      = req_payload.message_sequence == seq_ff;
      is_next     = !is_cur && (req_payload.message_sequence == seq_plus);
      next_raised = {1'b0, next_cnt_ff} + 9'd1;
      ign_raised  = {1'b0, ign_cnt_ff} + 9'd1;
      next_over   = is_next && !req_payload.end_of_frame
                    && (next_raised > {1'b0, next_limit_ff});
      ign_over    = !is_cur && !is_next && (ign_raised > {1'b0, ign_limit_ff});
      advance     = ((is_cur || is_next) && req_payload.end_of_frame) || next_over;
      hdr_copy    = pending_ff || advance
                    || (ign_over && (req_payload.end_of_frame
                                     || req_payload.last_of_message));
      data_copy   = write_on_ff && req_payload.last_of_message && pending_ff;
      in_range    = (offset_ff < seg_end_ff) && (17'(offset_ff) < FRAME_LIMIT);
      addr_hit    = 17'(req_payload.read_address) < FRAME_LIMIT;
      bank        = write_next_ff ? !sel_ff : sel_ff;
      data_addr   = AW'(offset_ff);
      data_wr     = cmd.accept && (req_payload.op == OP_DATA) && write_on_ff && in_range;
   end

   always_comb begin
      case (req_payload.op)
         OP_HEADER: status.need_copy = hdr_copy;
         OP_DATA:   status.need_copy = data_copy;
         default:   status.need_copy = 1'b0;
      endcase
      status.sweep_last = sweep_ff == LAST_ADDR;
   end

   always_comb begin
      seq_in        = seq_ff;
      next_cnt_in   = next_cnt_ff;
      ign_cnt_in    = ign_cnt_ff;
      class_in      = class_ff;
      offset_in     = offset_ff;
      seg_end_in    = seg_end_ff;
      write_on_in   = write_on_ff;
      write_next_in = write_next_ff;
      pending_in    = pending_ff;
      sel_in        = sel_ff;
      next_limit_in = next_limit_ff;
      ign_limit_in  = ign_limit_ff;
      updated_in    = updated_ff;
      rd_hit_in     = rd_hit_ff;
      copy_bank_in  = copy_bank_ff;
      sweep_in      = sweep_ff;
      copy_wr_in    = cmd.copy_read;
      copy_addr_in  = sweep_ff;

      if (cmd.accept) begin
         updated_in   = status.need_copy;
         rd_hit_in    = (req_payload.op == OP_READ) && addr_hit;
         copy_bank_in = sel_ff;
         case (req_payload.op)
            OP_HEADER: begin
               pending_in    = ign_over && !req_payload.end_of_frame
                               && !req_payload.last_of_message;
               write_on_in   = !req_payload.end_of_frame && (is_cur || is_next || ign_over)
                               && !req_payload.last_of_message;
               write_next_in = is_next && !req_payload.end_of_frame && !next_over;
               offset_in     = req_payload.range_start;
               seg_end_in    = req_payload.range_end;
               if (is_cur) begin
                  class_in = CLASS_CURRENT;
               end else if (is_next) begin
                  class_in = CLASS_NEXT;
               end else if (ign_over) begin
                  class_in = CLASS_RESYNC;
               end else begin
                  class_in = CLASS_IGNORED;
               end
               if (advance) begin
                  seq_in      = seq_plus;
                  sel_in      = !sel_ff;
                  next_cnt_in = 8'd0;
                  ign_cnt_in  = 8'd0;
               end else begin
                  if (ign_over) begin
                     seq_in = req_payload.message_sequence;
                  end
                  if (is_next) begin
                     next_cnt_in = saturate(next_raised);
                  end
                  if (!is_cur && !is_next) begin
                     ign_cnt_in = saturate(ign_raised);
                  end
               end
            end
            OP_DATA: begin
               if (write_on_ff) begin
                  if (in_range) begin
                     offset_in = offset_ff + 13'd1;
                  end
                  if (req_payload.last_of_message) begin
                     write_on_in = 1'b0;
                     pending_in  = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.clear || cmd.copy_read) begin
         sweep_in = status.sweep_last ? '0 : sweep_ff + 1'b1;
      end

      if (csr_write_enable) begin
         case (csr_index)
            CSR_NEXT_LIMIT:   next_limit_in = csr_write_data;
            CSR_IGNORE_LIMIT: ign_limit_in  = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff        <= '0;
         next_cnt_ff   <= '0;
         ign_cnt_ff    <= '0;
         class_ff      <= CLASS_IGNORED;
         offset_ff     <= '0;
         seg_end_ff    <= '0;
         write_on_ff   <= 1'b0;
         write_next_ff <= 1'b0;
         pending_ff    <= 1'b0;
         sel_ff        <= 1'b0;
         next_limit_ff <= LIMIT_RESET;
         ign_limit_ff  <= LIMIT_RESET;
         updated_ff    <= 1'b0;
         rd_hit_ff     <= 1'b0;
         copy_bank_ff  <= 1'b0;
         sweep_ff      <= '0;
         copy_wr_ff    <= 1'b0;
         copy_addr_ff  <= '0;
      end else begin
         seq_ff        <= seq_in;
         next_cnt_ff   <= next_cnt_in;
         ign_cnt_ff    <= ign_cnt_in;
         class_ff      <= class_in;
         offset_ff     <= offset_in;
         seg_end_ff    <= seg_end_in;
         write_on_ff   <= write_on_in;
         write_next_ff <= write_next_in;
         pending_ff    <= pending_in;
         sel_ff        <= sel_in;
         next_limit_ff <= next_limit_in;
         ign_limit_ff  <= ign_limit_in;
         updated_ff    <= updated_in;
         rd_hit_ff     <= rd_hit_in;
         copy_bank_ff  <= copy_bank_in;
         sweep_ff      <= sweep_in;
         copy_wr_ff    <= copy_wr_in;
         copy_addr_ff  <= copy_addr_in;
      end
   end

   // memory ports
   always_comb begin
      f0_we    = cmd.clear || (data_wr && !bank);
      f1_we    = cmd.clear || (data_wr && bank);
      frame_wa = cmd.clear ? sweep_ff : data_addr;
      frame_wd = cmd.clear ? 8'd0 : req_payload.data_byte;
      out_we   = cmd.clear || copy_wr_ff;
      out_wa   = cmd.clear ? sweep_ff : copy_addr_ff;
      out_wd   = cmd.clear ? 8'd0 : (copy_bank_ff ? frame1_rd_ff : frame0_rd_ff);
   end

   always_ff @(posedge clock) begin
      if (f0_we) begin
         frame0_mem[frame_wa] <= frame_wd;
      end
      frame0_rd_ff <= frame0_mem[sweep_ff];
   end

   always_ff @(posedge clock) begin
      if (f1_we) begin
         frame1_mem[frame_wa] <= frame_wd;
      end
      frame1_rd_ff <= frame1_mem[sweep_ff];
   end

   always_ff @(posedge clock) begin
      if (out_we) begin
         output_mem[out_wa] <= out_wd;
      end
      if (cmd.accept) begin
         output_rd_ff <= output_mem[AW'(req_payload.read_address)];
      end
   end

   always_comb begin
      rsp_payload.read_data      = rd_hit_ff ? output_rd_ff : 8'd0;
      rsp_payload.frame_sequence = seq_ff;
      rsp_payload.output_updated = updated_ff;
      rsp_payload.message_class  = class_ff;
   end

endmodule

>>> hw/rtl/sfsa_controller.sv
module sfsa_controller
   import sfsa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   output logic       rsp_strobe,
   output cmd_type    cmd,
   input  status_type status
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_COPY  = 2'd2;
   localparam logic [1:0] ST_TAIL  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       strobe_ff, strobe_in;

   always_comb begin
      state_in      = state_ff;
      strobe_in     = 1'b0;
      cmd.accept    = 1'b0;
      cmd.clear     = 1'b0;
      cmd.copy_read = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               if (status.need_copy) begin
                  state_in = ST_COPY;
               end else begin
                  strobe_in = 1'b1;
               end
            end
         end
         ST_COPY: begin
            cmd.copy_read = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            // last byte lands in the output buffer this cycle
            state_in  = ST_IDLE;
            strobe_in = 1'b1;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = strobe_ff;

   a_copy_entry: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && status.need_copy) |=> (state_ff == ST_COPY))
      else $error("publishing item did not start the copy");

   a_item_answered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (strobe_ff || state_ff == ST_COPY))
      else $error("accepted item neither answered nor copying");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> (state_ff == ST_IDLE))
      else $error("result strobe outside idle");

   a_tail_strobe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TAIL) |=> strobe_ff)
      else $error("copy finished without a result");

endmodule

>>> hw/rtl/sequenced_frame_segment_assembler.sv
// channel   ports                                          transfer
// request   start, busy, req_payload                       start high and busy low
// result    rsp_strobe, rsp_payload                        strobe high for one cycle
// config    csr_write_enable, csr_index, csr_write_data    write enable high
//
// headers, data bytes, reads and no-ops that do not publish get the result next cycle
// an item that publishes holds busy through the byte-wide copy from the frame store
//   to the output buffer, one byte per cycle, and then through a closing tail state
// after reset a clearing pass over every byte of the stores holds busy; config writes still taken
// the receiver cannot stall: every result is on the ports for exactly one cycle
module sequenced_frame_segment_assembler
   import sfsa_pkg::*;
#(
   parameter int FRAME_BYTES = 4096
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_payload,
   output logic       rsp_strobe,
   output rsp_type    rsp_payload,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [7:0] csr_write_data
);

   cmd_type    cmd;
   status_type status;

   sfsa_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   sfsa_datapath #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_payload      (rsp_payload)
   );

endmodule
